// ===== hdl/rf_rx_sample_source_top_assert.svh =====
// ---------------------------------------------------------------------------
// rf_rx_sample_source_top_assert.svh
// Assertion macros for the receiver sample source.
// ---------------------------------------------------------------------------
`ifndef RF_RX_SAMPLE_SOURCE_TOP_ASSERT_SVH
`define RF_RX_SAMPLE_SOURCE_TOP_ASSERT_SVH

// Same-cycle implication.
`define RFRX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfrx same-cycle check failed");

// Next-cycle implication.
`define RFRX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfrx next-cycle check failed");

`endif

// ===== hdl/rfrx_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rfrx_pkg
// Shared types, constants and tables of the receiver sample source.
// ---------------------------------------------------------------------------
package rfrx_pkg;

   localparam int CELL_ENTRIES_DEF = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_TONE_STEP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_LEVEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_SCALE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_AMP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FORCED_CHAN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_USE_SYNTH   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_COUNT  = 3'd6;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_SYNTH = 2'd1,
      CMD_TABLE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [31:0] LCG_MUL   = 32'd1103515245;
   localparam logic [31:0] LCG_INC   = 32'd12345;
   localparam logic [31:0] SEED_INIT = 32'h01234567;
   localparam logic [31:0] HASH_MUL  = 32'd2654435761;
   localparam logic [15:0] DUAL_MARK = 16'h0030;
   localparam logic [9:0]  MAX_CHAN  = 10'd1023;
   localparam logic [14:0] FULL_AMP  = 15'd32767;
   // floor(x * 43 / 256) == floor(x / 6) for 0 <= x < 90
   localparam logic [5:0]  RECIP6    = 6'd43;
   localparam logic [6:0]  ATT_LIMIT = 7'd90;

   typedef struct packed {
      logic signed [4:0]  tone_step;
      logic signed [8:0]  noise_level_dbm;
      logic signed [8:0]  full_scale_dbm;
      logic signed [15:0] raw_amplitude;
      logic signed [10:0] forced_channel;
      logic               use_synth_channel;
      logic [5:0]         cell_count;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic search;
      logic amp;
      logic gen;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic raw_sel;
      logic search_done;
   } dp_sts_type;

   function automatic logic [14:0] att_frac(input logic [2:0] r);
      logic [14:0] v;
      case (r)
         3'd0:    v = 15'd32767;
         3'd1:    v = 15'd29204;
         3'd2:    v = 15'd26028;
         3'd3:    v = 15'd23197;
         3'd4:    v = 15'd20675;
         3'd5:    v = 15'd18426;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] cos_val(input logic [3:0] ph);
      logic signed [15:0] v;
      case (ph)
         4'd0:    v = 16'sd32767;
         4'd1:    v = 16'sd30274;
         4'd2:    v = 16'sd23170;
         4'd3:    v = 16'sd12540;
         4'd4:    v = 16'sd0;
         4'd5:    v = -16'sd12540;
         4'd6:    v = -16'sd23170;
         4'd7:    v = -16'sd30274;
         4'd8:    v = -16'sd32767;
         4'd9:    v = -16'sd30274;
         4'd10:   v = -16'sd23170;
         4'd11:   v = -16'sd12540;
         4'd12:   v = 16'sd0;
         4'd13:   v = 16'sd12540;
         4'd14:   v = 16'sd23170;
         4'd15:   v = 16'sd30274;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/rf_rx_sample_source_top.sv =====
// Sequence: a read is captured and decoded, then walks the cell table (up to
// min(cell_count, CELL_ENTRIES) entries, one per cycle through the table read
// port) unless a fixed amplitude is set, then amplitude, generate and multiply;
// rsp_valid rises once the output register is free. Others end after decode.
// Reset: synchronous, active high; clears control, registers and tone state,
// the cell table stays undefined until written.
`default_nettype none
// ---------------------------------------------------------------------------
// rf_rx_sample_source_top
// Synthetic receiver sample source: synthesizer decode, cell level table,
// tone or noise I/Q sample generation.
// ---------------------------------------------------------------------------
`include "rf_rx_sample_source_top_assert.svh"

module rf_rx_sample_source_top #(
   parameter int CELL_ENTRIES = rfrx_pkg::CELL_ENTRIES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_cmd,
   input  wire logic [15:0]                       req_tap_channel,
   input  wire logic [15:0]                       req_word_low,
   input  wire logic [15:0]                       req_word_high,
   input  wire logic [2:0]                        req_packing_mode,
   input  wire logic [15:0]                       req_divider_offset,
   input  wire logic [4:0]                        req_table_index,
   input  wire logic [15:0]                       req_table_channel,
   input  wire logic signed [8:0]                 req_table_level_dbm,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [15:0]                     rsp_sample,
   output logic [9:0]                             rsp_channel,
   // configuration write port
   input  wire logic                              csr_write_en,
   input  wire logic [rfrx_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rfrx_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rfrx_pkg::cfg_type     cfg;
   rfrx_pkg::ctl_cmd_type ctl_cmd;
   rfrx_pkg::dp_sts_type  dp_sts;

   // Configuration registers; the user must write them only while no transaction is in flight (not enforced here).
   rfrx_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Sequencer: one transaction at a time, result held in the output
   // register so the next request is taken while the sample waits.
   rfrx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   // Datapath: capture, decode, table search, amplitude, generator, scaler.
   rfrx_dp #(
      .CELL_ENTRIES (CELL_ENTRIES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (ctl_cmd),
      .sts                 (dp_sts),
      .req_cmd             (req_cmd),
      .req_tap_channel     (req_tap_channel),
      .req_word_low        (req_word_low),
      .req_word_high       (req_word_high),
      .req_packing_mode    (req_packing_mode),
      .req_divider_offset  (req_divider_offset),
      .req_table_index     (req_table_index),
      .req_table_channel   (req_table_channel),
      .req_table_level_dbm (req_table_level_dbm),
      .rsp_sample          (rsp_sample),
      .rsp_channel         (rsp_channel)
   );

   // A taken transaction closes the request side in the cycle after acceptance.
   `RFRX_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // Never overwrite a sample that is still waiting to be taken.
   `RFRX_ASSERT_SAME(a_no_overwrite, clock, reset, ctl_cmd.load_out, !rsp_valid || rsp_ready)
   // A loaded sample is presented in the next cycle.
   `RFRX_ASSERT_NEXT(a_load_presents, clock, reset, ctl_cmd.load_out, rsp_valid)

endmodule
`default_nettype wire

// ===== hdl/rfrx_csr.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rfrx_csr
// Configuration register file, write-only.
// ---------------------------------------------------------------------------
module rfrx_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [rfrx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rfrx_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rfrx_pkg::cfg_type                       cfg
);

   rfrx_pkg::cfg_type cfg_ff;
   rfrx_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            rfrx_pkg::REG_TONE_STEP:   cfg_in.tone_step         = csr_wdata[4:0];
            rfrx_pkg::REG_NOISE_LEVEL: cfg_in.noise_level_dbm   = csr_wdata[8:0];
            rfrx_pkg::REG_FULL_SCALE:  cfg_in.full_scale_dbm    = csr_wdata[8:0];
            rfrx_pkg::REG_RAW_AMP:     cfg_in.raw_amplitude     = csr_wdata[15:0];
            rfrx_pkg::REG_FORCED_CHAN: cfg_in.forced_channel    = csr_wdata[10:0];
            rfrx_pkg::REG_USE_SYNTH:   cfg_in.use_synth_channel = csr_wdata[0];
            rfrx_pkg::REG_CELL_COUNT:  cfg_in.cell_count        = csr_wdata[5:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tone_step         <= 5'sd1;
         cfg_ff.noise_level_dbm   <= -9'sd110;
         cfg_ff.full_scale_dbm    <= -9'sd40;
         cfg_ff.raw_amplitude     <= -16'sd1;
         cfg_ff.forced_channel    <= -11'sd1;
         cfg_ff.use_synth_channel <= 1'b0;
         cfg_ff.cell_count        <= 6'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hdl/rfrx_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rfrx_ctrl
// Sequencer: steps one transaction through decode and, for a read, search
// (skipped with a fixed amplitude), amplitude, generate and multiply phases and owns the result valid flag.
// ---------------------------------------------------------------------------
module rfrx_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  rfrx_pkg::dp_sts_type       sts,
   output rfrx_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_AMP,
      ST_GEN,
      ST_MUL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (!sts.is_read)     state_in = ST_IDLE;
            else if (sts.raw_sel) state_in = ST_AMP;
            else                  state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.search_done) state_in = ST_AMP;
         end
         ST_AMP: begin
            cmd.amp  = 1'b1;
            state_in = ST_GEN;
         end
         ST_GEN: begin
            cmd.gen  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // hold until the output register can take the new sample
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/rfrx_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rfrx_dp
// Datapath: request capture, synthesizer decode, cell table memory with
// serial search, amplitude conversion, tone/noise generator and scaler.
// ---------------------------------------------------------------------------
module rfrx_dp #(
   parameter int CELL_ENTRIES = rfrx_pkg::CELL_ENTRIES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  rfrx_pkg::cfg_type         cfg,
   input  rfrx_pkg::ctl_cmd_type     cmd,
   output rfrx_pkg::dp_sts_type      sts,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [15:0]          req_tap_channel,
   input  wire logic [15:0]          req_word_low,
   input  wire logic [15:0]          req_word_high,
   input  wire logic [2:0]           req_packing_mode,
   input  wire logic [15:0]          req_divider_offset,
   input  wire logic [4:0]           req_table_index,
   input  wire logic [15:0]          req_table_channel,
   input  wire logic signed [8:0]    req_table_level_dbm,
   output logic signed [15:0]        rsp_sample,
   output logic [9:0]                rsp_channel
);

   localparam int IDX_W = (CELL_ENTRIES > 1) ? $clog2(CELL_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CELL_ENTRIES + 1);

   // captured transaction
   rfrx_pkg::cmd_type  cmd_ff;
   logic [15:0]        tap_ff, lo_ff, hi_ff, off_ff, tch_ff;
   logic [2:0]         mode_ff;
   logic [4:0]         tidx_ff;
   logic signed [8:0]  tlv_ff;

   // persistent state
   logic [15:0]        synth_ff;
   logic [10:0]        last_ff;
   logic [3:0]         phase_ff;
   logic               parity_ff;
   logic [31:0]        seed_ff;

   // per-read working registers
   logic [9:0]         ch_ff;
   logic [CNT_W-1:0]   lim_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               rd_vld_ff;
   logic [15:0]        rd_ch_ff;
   logic signed [8:0]  rd_lv_ff;
   logic signed [8:0]  level_ff;
   logic [14:0]        amp_ff;
   logic signed [15:0] op_ff;
   logic signed [15:0] sample_ff;
   logic [9:0]         chan_out_ff;

   // cell table
   logic [15:0]        cell_ch_mem [CELL_ENTRIES];
   logic signed [8:0]  cell_lv_mem [CELL_ENTRIES];

   // ---- synthesizer word decode ----
   logic [18:0] syn_n;
   logic        syn_fmt_ok;
   logic [19:0] syn_diff;
   logic        syn_ok;

   always_comb begin
      syn_n      = '0;
      syn_fmt_ok = 1'b0;
      if (mode_ff[2]) begin
         syn_fmt_ok = ((hi_ff & rfrx_pkg::DUAL_MARK) == rfrx_pkg::DUAL_MARK);
         syn_n      = {hi_ff[3:0], lo_ff[15:7], lo_ff[5:0]};
      end else if (mode_ff[1]) begin
         syn_fmt_ok = (hi_ff == 16'd0) && (lo_ff[1:0] == 2'b11);
         syn_n      = 19'({lo_ff[15:9], lo_ff[7:2]});
      end
      syn_diff = {1'b0, syn_n} - {4'd0, off_ff};
      syn_ok   = syn_fmt_ok && !syn_diff[19] && (syn_diff[18:10] == 9'd0);
   end

   // ---- channel select ----
   logic [15:0] sel_ch;
   logic [9:0]  pick_ch;
   logic [31:0] lim_int;

   always_comb begin
      sel_ch = cfg.use_synth_channel ? synth_ff : tap_ff;
      if (!cfg.forced_channel[10]) sel_ch = {6'd0, cfg.forced_channel[9:0]};
      if (sel_ch[15:10] != 6'd0) pick_ch = last_ff[10] ? 10'd0 : last_ff[9:0];
      else                       pick_ch = sel_ch[9:0];
      lim_int = (32'(cfg.cell_count) < 32'(CELL_ENTRIES)) ?
                32'(cfg.cell_count) : 32'(CELL_ENTRIES);
   end

   // ---- serial search ----
   logic issue;
   logic hit;
   logic tbl_ok;

   assign issue  = cmd.search && (cnt_ff < lim_ff);
   assign hit    = rd_vld_ff && (rd_ch_ff == {6'd0, ch_ff});
   assign tbl_ok = (32'(tidx_ff) < 32'(CELL_ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.decode && (cmd_ff == rfrx_pkg::CMD_TABLE) && tbl_ok) begin
         cell_ch_mem[IDX_W'(tidx_ff)] <= tch_ff;
         cell_lv_mem[IDX_W'(tidx_ff)] <= tlv_ff;
      end
      if (issue) begin
         rd_ch_ff <= cell_ch_mem[cnt_ff[IDX_W-1:0]];
         rd_lv_ff <= cell_lv_mem[cnt_ff[IDX_W-1:0]];
      end
   end

   // ---- amplitude ----
   logic signed [10:0] att;
   logic [12:0]        q_prod;
   logic [4:0]         oct;
   logic [6:0]         rem_full;
   logic [14:0]        amp_calc;

   always_comb begin
      att      = 11'(cfg.full_scale_dbm) - 11'(level_ff);
      q_prod   = 13'(att[6:0]) * 13'(rfrx_pkg::RECIP6);
      oct      = q_prod[12:8];
      rem_full = att[6:0] - 7'(oct * 3'd6);
      if (att[10] || (att == 11'sd0))
         amp_calc = rfrx_pkg::FULL_AMP;
      else if ((att[9:7] != 3'd0) || (att[6:0] >= rfrx_pkg::ATT_LIMIT))
         amp_calc = 15'd0;
      else
         amp_calc = rfrx_pkg::att_frac(rem_full[2:0]) >> oct;
      if (!cfg.raw_amplitude[15]) amp_calc = cfg.raw_amplitude[14:0];
   end

   // ---- generator and scaler ----
   logic               noise_mode;
   logic signed [15:0] noise_val;
   logic signed [15:0] mul_a;
   logic signed [31:0] prod;

   assign noise_mode = cfg.tone_step[4];
   assign noise_val  = {~seed_ff[31], seed_ff[30:16]};
   assign mul_a      = noise_mode ? noise_val : op_ff;
   assign prod       = mul_a * $signed({1'b0, amp_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= rfrx_pkg::cmd_type'(req_cmd);
         tap_ff  <= req_tap_channel;
         lo_ff   <= req_word_low;
         hi_ff   <= req_word_high;
         mode_ff <= req_packing_mode;
         off_ff  <= req_divider_offset;
         tidx_ff <= req_table_index;
         tch_ff  <= req_table_channel;
         tlv_ff  <= req_table_level_dbm;
      end
      if (cmd.decode) begin
         ch_ff    <= pick_ch;
         lim_ff   <= CNT_W'(lim_int);
         cnt_ff   <= '0;
         level_ff <= cfg.noise_level_dbm;
      end else if (issue) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.search && hit) level_ff <= rd_lv_ff;
      if (cmd.amp) amp_ff <= amp_calc;
      if (cmd.gen) begin
         op_ff <= parity_ff ? rfrx_pkg::cos_val(phase_ff - 4'd4)
                            : rfrx_pkg::cos_val(phase_ff);
      end
      if (cmd.load_out) begin
         sample_ff   <= prod[30:15];
         chan_out_ff <= ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synth_ff  <= 16'hFFFF;
         last_ff   <= 11'h7FF;
         phase_ff  <= 4'd0;
         parity_ff <= 1'b0;
         seed_ff   <= rfrx_pkg::SEED_INIT;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.decode && (cmd_ff == rfrx_pkg::CMD_SYNTH) && syn_ok)
            synth_ff <= {6'd0, syn_diff[9:0]};
         if (cmd.amp && ({1'b0, ch_ff} != last_ff)) begin
            // retune: restart phase, parity and noise sequence
            last_ff   <= {1'b0, ch_ff};
            phase_ff  <= 4'd0;
            parity_ff <= 1'b0;
            seed_ff   <= rfrx_pkg::SEED_INIT ^ 32'({22'd0, ch_ff} * rfrx_pkg::HASH_MUL);
         end
         if (cmd.gen) begin
            if (noise_mode) begin
               seed_ff <= 32'(seed_ff * rfrx_pkg::LCG_MUL) + rfrx_pkg::LCG_INC;
            end else begin
               if (parity_ff) phase_ff <= phase_ff + cfg.tone_step[3:0];
               parity_ff <= !parity_ff;
            end
         end
      end
   end

   assign sts.is_read     = (cmd_ff == rfrx_pkg::CMD_READ);
   assign sts.raw_sel     = !cfg.raw_amplitude[15];
   assign sts.search_done = hit || (!rd_vld_ff && (cnt_ff >= lim_ff));

   assign rsp_sample  = sample_ff;
   assign rsp_channel = chan_out_ff;

endmodule
`default_nettype wire
